FILE: hdl/brl_pkg.sv
// Shared types and constants of the Bresenham line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

  localparam int COORD_W = 18;
  localparam int IN_FIELDS = 4;
  localparam int IN_TDATA_W = ((COORD_W * IN_FIELDS + 7) / 8) * 8;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

  typedef struct packed {
    logic load;
    logic scale;
    logic orient;
    logic prep;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic hit;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/bresenham_line_rasterizer.sv
// Setup states SCALE, ORIENT and PREP follow an accept, then the major-axis walk.
// A pixel is held one stage and reaches the output register with the next hit or at flush.
// One segment at a time: the next is accepted only after the last one's walk and flush.
// The walk runs from the truncated major start to the truncated major end or the image
// edge, up to 3 * side steps; a hit stalls it while a pixel is held and output waits.
// Synchronous active-high reset clears control state and sets image_side to 64.
`timescale 1ns / 1ps

module bresenham_line_rasterizer #(
  parameter int MAX_SIDE = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [brl_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // u_start, v_start, u_end, v_end
  input  logic [brl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, byte_address, zero fill
  output logic [((2 * $clog2(MAX_SIDE) + $clog2(MAX_SIDE * MAX_SIDE * 4) + 7) / 8) * 8 - 1:0]
                                         m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int PIX_W = $clog2(MAX_SIDE);
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE * 4);
  localparam int OUT_TDATA_W = ((2 * PIX_W + ADDR_W + 7) / 8) * 8;

  brl_pkg::cmd_t    cmd;
  brl_pkg::status_t st;

  brl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  brl_datapath #(
    .MAX_SIDE    (MAX_SIDE),
    .FRAC_BITS   (FRAC_BITS),
    .PIX_W       (PIX_W),
    .ADDR_W      (ADDR_W),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .st            (st),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: hdl/brl_ctrl.sv
// Sequencing state machine of the Bresenham line rasterizer.
`timescale 1ns / 1ps

module brl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  brl_pkg::status_t st,
  output brl_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCALE,
    ORIENT,
    PREP,
    WALK,
    FLUSH
  } state_t;

  state_t state;
  logic   stall;

  assign stall = st.hit && st.pend_valid && !st.out_free;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:   cmd.load = s_axis_tvalid && s_axis_tready;
      SCALE:  cmd.scale = 1'b1;
      ORIENT: cmd.orient = 1'b1;
      PREP:   cmd.prep = 1'b1;
      WALK:   cmd.step = st.active && !stall;
      FLUSH:  cmd.flush = st.pend_valid && st.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      s_axis_tready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            state <= SCALE;
            s_axis_tready <= 1'b0;
          end
        end
        SCALE:  state <= ORIENT;
        ORIENT: state <= PREP;
        PREP:   state <= WALK;
        WALK: begin
          if (!st.active) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          if (!st.pend_valid || st.out_free) begin
            state <= IDLE;
            s_axis_tready <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          s_axis_tready <= 1'b1;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == IDLE)
    else $error("input ready outside idle");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == WALK) && !st.active |=> state == FLUSH)
    else $error("walk did not end in flush");

  a_no_stall_step: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == WALK) && !(st.pend_valid && st.hit && !st.out_free))
    else $error("step issued while output is blocked");

endmodule

FILE: hdl/brl_datapath.sv
// Scaling, orientation and Bresenham walk datapath with output register.
`timescale 1ns / 1ps

module brl_datapath #(
  parameter int MAX_SIDE = 64,
  parameter int FRAC_BITS = 16,
  parameter int PIX_W = 6,
  parameter int ADDR_W = 14,
  parameter int OUT_TDATA_W = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [brl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [brl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  brl_pkg::cmd_t                 cmd,
  output brl_pkg::status_t              st,
  input  logic                          m_axis_tready,
  output logic                          m_axis_tvalid,
  output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int CW = brl_pkg::COORD_W;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PROD_W = CW + SIDE_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int E_W = PROD_W + 4;
  localparam int POS_RAW = PROD_W - FRAC_BITS + 2;
  localparam int POS_W = (POS_RAW > SIDE_W + 2) ? POS_RAW : SIDE_W + 2;
  localparam int TR_W = POS_W + FRAC_BITS;

  function automatic logic signed [PROD_W-1:0] mul_side(input logic signed [CW-1:0] c,
                                                        input logic [SIDE_W-1:0] s);
    logic signed [PROD_W:0] p;
    p = c * $signed({1'b0, s});
    return p[PROD_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] trunc_fix(input logic signed [PROD_W-1:0] v);
    logic signed [TR_W-1:0] t;
    t = {{(TR_W - PROD_W){v[PROD_W-1]}}, v};
    if (v[PROD_W-1]) begin
      t = t + TR_W'((1 << FRAC_BITS) - 1);
    end
    return t[FRAC_BITS +: POS_W];
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [PROD_W-1:0] hi,
                                                     input logic signed [PROD_W-1:0] lo);
    return {hi[PROD_W-1], hi} - {lo[PROD_W-1], lo};
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

  logic [brl_pkg::CFG_W-1:0] image_side;
  logic [SIDE_W-1:0]         side_eff;
  logic [SIDE_W-1:0]         side_q;

  logic signed [CW-1:0]      u1, v1, u2, v2;
  logic signed [PROD_W-1:0]  a1, b1, a2, b2;

  logic signed [POS_W-1:0]   major_pos, major_end, minor_pos;
  logic signed [E_W-1:0]     error_acc;
  logic [DIFF_W-1:0]         delta_major, delta_minor;
  logic                      minor_step_neg;
  logic                      steep_flag;

  logic [PIX_W-1:0]          pend_x, pend_y, out_x, out_y;
  logic [ADDR_W-1:0]         pend_addr, out_addr;
  logic                      pend_valid, out_valid, out_last;

  // Orientation and ordering terms.
  logic [DIFF_W-1:0]         du_mag, dv_mag;
  logic                      steep;
  logic                      swap_ends;
  logic signed [PROD_W-1:0]  oa1, ob1, oa2, ob2;

  // Walk terms.
  logic signed [POS_W-1:0]   side_s;
  logic [PIX_W-1:0]          px, py;
  logic [ADDR_W-1:0]         row_base, addr;
  logic signed [E_W-1:0]     e_sub;
  logic                      out_free;

  always_comb begin
    if (image_side == '0) begin
      side_eff = SIDE_W'(1);
    end else if (int'(image_side) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(image_side);
    end
  end

  always_comb begin
    du_mag = mag(sdiff(a2, a1));
    dv_mag = mag(sdiff(b2, b1));
    steep = dv_mag > du_mag;
    swap_ends = a1 > a2;
    oa1 = swap_ends ? a2 : a1;
    ob1 = swap_ends ? b2 : b1;
    oa2 = swap_ends ? a1 : a2;
    ob2 = swap_ends ? b1 : b2;
  end

  always_comb begin
    side_s = $signed({{(POS_W - SIDE_W){1'b0}}, side_q});
    st.active = (major_pos <= major_end) && (major_pos < side_s);
    st.hit = !major_pos[POS_W-1] && !minor_pos[POS_W-1] && (minor_pos < side_s);
    px = steep_flag ? minor_pos[PIX_W-1:0] : major_pos[PIX_W-1:0];
    py = steep_flag ? major_pos[PIX_W-1:0] : minor_pos[PIX_W-1:0];
    row_base = ADDR_W'(py) * ADDR_W'(side_q);
    addr = (row_base + ADDR_W'(px)) << 2;
    e_sub = error_acc - $signed(E_W'({delta_minor, 1'b0}));
    out_free = !out_valid || m_axis_tready;
    st.out_free = out_free;
    st.pend_valid = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= brl_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      image_side <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos <= '0;
      major_end <= '0;
      minor_pos <= '0;
      error_acc <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      minor_step_neg <= 1'b0;
      steep_flag <= 1'b0;
    end else begin
      if (cmd.orient) begin
        steep_flag <= steep;
      end
      if (cmd.prep) begin
        delta_major <= $unsigned(sdiff(oa2, oa1));
        delta_minor <= mag(sdiff(ob2, ob1));
        minor_step_neg <= !(ob1 < ob2);
        error_acc <= $signed(E_W'($unsigned(sdiff(oa2, oa1))));
        minor_pos <= trunc_fix(ob1);
        major_pos <= trunc_fix(oa1);
        major_end <= trunc_fix(oa2);
      end
      if (cmd.step) begin
        major_pos <= major_pos + POS_W'(1);
        if (e_sub[E_W-1]) begin
          minor_pos <= minor_step_neg ? minor_pos - POS_W'(1) : minor_pos + POS_W'(1);
          error_acc <= e_sub + $signed(E_W'({delta_major, 1'b0}));
        end else begin
          error_acc <= e_sub;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u1 <= s_axis_tdata[0*CW +: CW];
      v1 <= s_axis_tdata[1*CW +: CW];
      u2 <= s_axis_tdata[2*CW +: CW];
      v2 <= s_axis_tdata[3*CW +: CW];
      side_q <= side_eff;
    end
    if (cmd.scale) begin
      a1 <= mul_side(u1, side_q);
      b1 <= mul_side(v1, side_q);
      a2 <= mul_side(u2, side_q);
      b2 <= mul_side(v2, side_q);
    end
    if (cmd.orient && steep) begin
      a1 <= b1;
      b1 <= a1;
      a2 <= b2;
      b2 <= a2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.step && st.hit) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && st.hit) begin
      pend_x <= px;
      pend_y <= py;
      pend_addr <= addr;
    end
    if ((cmd.step && st.hit && pend_valid) || cmd.flush) begin
      out_x <= pend_x;
      out_y <= pend_y;
      out_addr <= pend_addr;
      out_last <= cmd.flush;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_TDATA_W'({out_addr, out_y, out_x});
  assign m_axis_tlast = out_last;

  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pend_valid)
    else $error("pending pixel left over from previous segment");

  a_pixel_in_image: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (SIDE_W'(out_x) < side_q) && (SIDE_W'(out_y) < side_q))
    else $error("pixel outside image");

  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> m_axis_tvalid && m_axis_tlast && !pend_valid)
    else $error("flush did not present the last pixel");

endmodule
